/* hdl/three_sat_clause_checker_top_macros.svh */
// assertion macros shared by the checker
`ifndef THREE_SAT_CLAUSE_CHECKER_TOP_MACROS_SVH
`define THREE_SAT_CLAUSE_CHECKER_TOP_MACROS_SVH

// same-cycle implication, disabled while in reset
`define TSC_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define TSC_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/tsc_pkg.sv */
package tsc_pkg;

	localparam int CLAUSE_DEPTH_DEF = 128;
	localparam int VAR_COUNT_DEF    = 32;

	typedef enum logic [0:0] {
		OP_LOAD = 1'b0,
		OP_EVAL = 1'b1
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [6:0]  clause_index;
		logic [4:0]  var_first;
		logic [4:0]  var_second;
		logic [4:0]  var_third;
		logic        pol_first;
		logic        pol_second;
		logic        pol_third;
		logic [31:0] assignment;
	} in_item_t;

	typedef struct packed {
		logic [7:0] satisfied_count;
		logic       all_satisfied;
	} out_item_t;

	// one stored clause
	typedef struct packed {
		logic       pol_third;
		logic       pol_second;
		logic       pol_first;
		logic [4:0] var_third;
		logic [4:0] var_second;
		logic [4:0] var_first;
	} entry_t;

	// variables at or above the limit read as false
	function automatic logic var_value(logic [31:0] assign_v, logic [4:0] v,
			logic [6:0] var_limit);
		logic in_range;
		in_range = ({2'b00, v} < var_limit);
		return in_range & assign_v[v];
	endfunction

	function automatic logic clause_holds(entry_t e, logic [31:0] assign_v,
			logic [6:0] var_limit);
		logic l0, l1, l2;
		l0 = (var_value(assign_v, e.var_first,  var_limit) == e.pol_first);
		l1 = (var_value(assign_v, e.var_second, var_limit) == e.pol_second);
		l2 = (var_value(assign_v, e.var_third,  var_limit) == e.pol_third);
		return l0 | l1 | l2;
	endfunction

endpackage

/* hdl/three_sat_clause_checker_top.sv */
// 3-SAT clause checker. A load item (op = load) writes one three-literal clause
// into the clause table at clause_index and gives no result; indexes at or
// beyond CLAUSE_DEPTH are dropped. An evaluate item (op = eval) carries a full
// assignment and gives one result: how many of the first clause_count clauses
// hold at least one true literal, and a flag set when all of them do
// (clause_count saturates at CLAUSE_DEPTH; zero clauses reports all satisfied).
// The table sits in a synchronous RAM with separate write and read ports, read
// one clause per cycle; an evaluation occupies the block from acceptance until
// its result enters the result register, waiting while that register holds an
// earlier result; a load leaves it idle. One item is worked on at a time. The
// result register lets a load be taken while an earlier result still waits. The
// user must write clause_count through the cfg channel only while idle; the block
// does not enforce it. Entries never loaded since reset read back as garbage.
module three_sat_clause_checker_top
	import tsc_pkg::*;
#(
	parameter int CLAUSE_DEPTH = CLAUSE_DEPTH_DEF,
	parameter int VAR_COUNT    = VAR_COUNT_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic [7:0] cfg_data
);

	// table address width and walk counter width (at least the 8-bit count)
	localparam int AW = (CLAUSE_DEPTH > 1) ? $clog2(CLAUSE_DEPTH) : 1;
	localparam int IW = (AW > 8) ? AW : 8;
	localparam logic [IW:0] DEPTH_W   = (IW + 1)'(CLAUSE_DEPTH);
	localparam logic [6:0]  VAR_LIMIT = 7'(VAR_COUNT);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_FINISH
	} state_t;

	state_t      state_q;
	logic [7:0]  clause_count_q;
	logic [31:0] assign_q;
	logic [7:0]  used_q;
	logic [IW-1:0] issue_q;
	logic        issuing_q;
	logic        rd_vld_s1;
	logic        rd_last_s1;
	entry_t      rd_data_s1;
	logic [7:0]  sat_q;
	logic        out_valid_q;
	out_item_t   out_data_q;

	// clause table
	entry_t      clause_mem [CLAUSE_DEPTH];

	logic        in_fire;
	logic        wr_en;
	logic [IW-1:0] wr_idx;
	logic [IW:0] cnt_ext;
	logic [IW:0] used_w;
	logic [IW-1:0] issue_nxt;
	logic        issue_last;
	logic        holds;
	logic        res_load;
	entry_t      wr_entry;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid & in_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// load path: drop indexes beyond the table
	assign wr_idx = IW'(in_data.clause_index);
	assign wr_en  = in_fire && (in_data.op == OP_LOAD) && ({1'b0, wr_idx} < DEPTH_W);

	always_comb begin
		wr_entry.var_first  = in_data.var_first;
		wr_entry.var_second = in_data.var_second;
		wr_entry.var_third  = in_data.var_third;
		wr_entry.pol_first  = in_data.pol_first;
		wr_entry.pol_second = in_data.pol_second;
		wr_entry.pol_third  = in_data.pol_third;
	end

	// clauses in use, saturated at the table depth
	assign cnt_ext = (IW + 1)'(clause_count_q);
	assign used_w  = (cnt_ext > DEPTH_W) ? DEPTH_W : cnt_ext;

	// walk control: last read issued when the next address reaches the count
	assign issue_nxt  = issue_q + 1'b1;
	assign issue_last = (issue_nxt == IW'(used_q));

	// clause test on the registered read data
	assign holds = clause_holds(rd_data_s1, assign_q, VAR_LIMIT);

	// result register loads once the slot is free
	assign res_load = (state_q == ST_FINISH) && (!out_valid_q || out_ready);

	// separate write and read ports: write on load, one read per cycle during the walk
	always_ff @(posedge clk) begin
		if (wr_en) begin
			clause_mem[wr_idx[AW-1:0]] <= wr_entry;
		end
		rd_data_s1 <= clause_mem[issue_q[AW-1:0]];
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clause_count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			clause_count_q <= cfg_data;
		end
	end

	// sequencer, accumulator and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			assign_q    <= '0;
			used_q      <= '0;
			issue_q     <= '0;
			issuing_q   <= 1'b0;
			rd_vld_s1   <= 1'b0;
			rd_last_s1  <= 1'b0;
			sat_q       <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			// new result, or result taken downstream
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			// read data arrives in the cycle after its address
			rd_vld_s1 <= (state_q == ST_EVAL) && issuing_q;

			unique case (state_q)
				ST_IDLE: begin
					if (in_fire && (in_data.op == OP_EVAL)) begin
						assign_q  <= in_data.assignment;
						used_q    <= used_w[7:0];
						issue_q   <= '0;
						sat_q     <= '0;
						issuing_q <= (used_w != '0);
						state_q   <= (used_w == '0) ? ST_FINISH : ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (issuing_q) begin
						rd_last_s1 <= issue_last;
						issue_q    <= issue_nxt;
						if (issue_last) begin
							issuing_q <= 1'b0;
						end
					end
					if (rd_vld_s1) begin
						sat_q <= sat_q + 8'(holds);
						if (rd_last_s1) begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_FINISH: begin
					// wait for the result slot to be free
					if (res_load) begin
						out_data_q.satisfied_count <= sat_q;
						out_data_q.all_satisfied   <= (sat_q == used_q);
						state_q                    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* hdl/tsc_checker.sv */
`include "three_sat_clause_checker_top_macros.svh"

module tsc_checker
	import tsc_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input in_item_t  in_data,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_data,
	input logic      cfg_valid,
	input logic      cfg_ready,
	input logic [7:0] cfg_data
);

	logic eval_fire;
	logic load_fire;
	logic cfg_fire;

	assign eval_fire = in_valid && in_ready && (in_data.op == OP_EVAL);
	assign load_fire = in_valid && in_ready && (in_data.op == OP_LOAD);
	assign cfg_fire  = cfg_valid && cfg_ready && (cfg_data == cfg_data);

	// a waiting result holds
	`TSC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result dropped or changed while stalled")

	// an evaluation keeps the block busy in the next cycle
	`TSC_ASSERT_NEXT(a_eval_busy, clk, arst_n, eval_fire, !in_ready, "input taken during an evaluation")

	// a load leaves the block ready in the next cycle
	`TSC_ASSERT_NEXT(a_load_done, clk, arst_n, load_fire, in_ready, "block busy after a load")

	// configuration is always taken
	`TSC_ASSERT_NOW(a_cfg_ready, clk, arst_n, cfg_valid, cfg_ready || cfg_fire, "configuration write refused")

endmodule

bind three_sat_clause_checker_top tsc_checker u_tsc_checker (.*);
